### rtl/hsd_pkg.sv
// shared types, constants and datapath operation codes for the huffman stream decoder
`default_nettype none

package hsd_pkg;

   localparam int ALPHABET_SIZE = 256;
   localparam logic [31:0] MAGIC_WORD = 32'h314D4648;

   // datapath operations
   localparam logic [4:0] OP_NONE    = 5'd0;
   localparam logic [4:0] OP_MAGIC   = 5'd1;
   localparam logic [4:0] OP_COUNT   = 5'd2;
   localparam logic [4:0] OP_SYM     = 5'd3;
   localparam logic [4:0] OP_FREQ    = 5'd4;
   localparam logic [4:0] OP_BITS    = 5'd5;
   localparam logic [4:0] OP_PAY     = 5'd6;
   localparam logic [4:0] OP_SCAN_RD = 5'd7;
   localparam logic [4:0] OP_SCAN_WR = 5'd8;
   localparam logic [4:0] OP_Q_RD0   = 5'd9;
   localparam logic [4:0] OP_Q_LD0   = 5'd10;
   localparam logic [4:0] OP_Q_RD    = 5'd11;
   localparam logic [4:0] OP_Q_CMP   = 5'd12;
   localparam logic [4:0] OP_TAIL_RD = 5'd13;
   localparam logic [4:0] OP_TAIL_WR = 5'd14;
   localparam logic [4:0] OP_MERGE   = 5'd15;
   localparam logic [4:0] OP_ROOT_RD = 5'd16;
   localparam logic [4:0] OP_ROOT_LD = 5'd17;
   localparam logic [4:0] OP_LEAF    = 5'd18;
   localparam logic [4:0] OP_NODE_RD = 5'd19;
   localparam logic [4:0] OP_EVAL    = 5'd20;
   localparam logic [4:0] OP_END     = 5'd21;

   typedef struct packed {
      logic [8:0]  node;
      logic [63:0] freq;
   } q_entry_type;

   typedef struct packed {
      logic [4:0] op;
      logic       clear;
      logic       second;
   } hsd_cmd_type;

   typedef struct packed {
      logic field_done;
      logic magic_ok;
      logic count_zero;
      logic entries_last;
      logic bits_zero;
      logic scan_last;
      logic queue_empty;
      logic queue_one;
      logic i_end;
      logic bits_done;
      logic root_leaf;
      logic bit_last;
      logic pend_valid;
      logic out_valid;
      logic out_free;
   } hsd_status_type;

endpackage

`default_nettype wire

### rtl/hsd_if.sv
// valid/ready channel interfaces for compressed input bytes and decoded results
`default_nettype none

interface hsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_start;

   modport source (output valid, output data_byte, output file_start, input ready);
   modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface hsd_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] symbol;
   logic       last_result;

   modport source (output valid, output result_kind, output symbol, output last_result,
                   input ready);
   modport sink (input valid, input result_kind, input symbol, input last_result,
                 output ready);
endinterface

`default_nettype wire

### rtl/huffman_stream_decoder_top.sv
// huffman stream decoder: header bytes are accepted one at a time once the result register is free
// after the bit count, the tree build scans all 256 frequency table entries (read, then queue write), then per merge
// runs two least-node searches over the n-entry merge queue memory, each reading and comparing every entry
// payload bytes take an accept step, one leaf step per bit for a one-symbol tree or a node table read
// then a step per bit, and a byte end step; a byte takes longer while results wait
// synchronous reset clears control state and the frequency valid bits; no clearing pass
`default_nettype none

module huffman_stream_decoder_top (
   input  logic      clock,
   input  logic      reset,
   hsd_req_if.sink   req_chan,
   hsd_rsp_if.source rsp_chan
);
   import hsd_pkg::*;

   hsd_cmd_type    cmd;
   hsd_status_type status;

   hsd_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_file_start (req_chan.file_start),
      .status         (status),
      .req_ready      (req_chan.ready),
      .cmd            (cmd)
   );

   hsd_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .data_byte       (req_chan.data_byte),
      .rsp_ready       (rsp_chan.ready),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_result_kind (rsp_chan.result_kind),
      .rsp_symbol      (rsp_chan.symbol),
      .rsp_last_result (rsp_chan.last_result)
   );

endmodule

`default_nettype wire

### rtl/hsd_datapath.sv
// header fields, frequency table, merge queue, node table, bit walk and result register
`default_nettype none

module hsd_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  hsd_pkg::hsd_cmd_type    cmd,
   input  logic [7:0]              data_byte,
   input  logic                    rsp_ready,
   output hsd_pkg::hsd_status_type status,
   output logic                    rsp_valid,
   output logic                    rsp_result_kind,
   output logic [7:0]              rsp_symbol,
   output logic                    rsp_last_result
);
   import hsd_pkg::*;

   logic [2:0]  seen_ff, seen_in, eff_seen;
   logic [55:0] asm_ff, asm_in, eff_asm, take_asm;
   logic [63:0] field_full;
   logic [15:0] count_val;
   logic [15:0] entries_ff, entries_in;
   logic [7:0]  entry_sym_ff, entry_sym_in;
   logic [ALPHABET_SIZE-1:0] valid_ff, valid_in;
   logic        done;

   logic [63:0] freq_mem [0:ALPHABET_SIZE-1];
   logic [63:0] freq_rd_ff;
   logic        fv_rd_ff;
   logic        freq_we;

   q_entry_type q_mem [0:ALPHABET_SIZE-1];
   q_entry_type q_rd_ff, q_wdata;
   logic [7:0]  q_waddr, q_raddr;
   logic        q_we;

   logic [17:0] node_mem [0:ALPHABET_SIZE-1];
   logic [17:0] node_rd_ff;
   logic        node_we;

   logic [7:0]  scan_idx_ff, scan_idx_in;
   logic [8:0]  count_ff, count_in, count_dec;
   logic [8:0]  i_ff, i_in;
   q_entry_type best_ff, best_in, pa_ff, pa_in, pb_ff, pb_in;
   logic [7:0]  best_idx_ff, best_idx_in;
   logic [7:0]  io_ff, io_in;
   logic [8:0]  root_ff, root_in, walk_ff, walk_in, child;
   logic [63:0] total_ff, total_in, consumed_ff, consumed_in;
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  bit_idx_ff, bit_idx_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_sym_ff, pend_sym_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [7:0]  out_sym_ff, out_sym_in;
   logic        out_last_ff, out_last_in;
   logic        prod;
   logic [7:0]  prod_sym;
   logic        is_less;

   assign eff_seen   = cmd.clear ? 3'd0 : seen_ff;
   assign eff_asm    = cmd.clear ? 56'd0 : asm_ff;
   assign field_full = {data_byte, eff_asm};
   assign count_val  = {data_byte, eff_asm[7:0]};
   assign count_dec  = count_ff - 9'd1;
   assign child      = byte_ff[bit_idx_ff] ? node_rd_ff[8:0] : node_rd_ff[17:9];
   assign is_less    = {q_rd_ff.freq, ~q_rd_ff.node[8], q_rd_ff.node[7:0]} <
                       {best_ff.freq, ~best_ff.node[8], best_ff.node[7:0]};

   always_comb begin
      for (int k = 0; k < 7; k++) begin
         take_asm[8*k +: 8] = (eff_seen == 3'(k)) ? data_byte : eff_asm[8*k +: 8];
      end
   end

   assign done = ((cmd.op == OP_MAGIC) && (eff_seen == 3'd3)) ||
                 ((cmd.op == OP_COUNT) && (eff_seen == 3'd1)) ||
                 (((cmd.op == OP_FREQ) || (cmd.op == OP_BITS)) && (eff_seen == 3'd7));

   always_comb begin
      seen_in       = seen_ff;
      asm_in        = asm_ff;
      entries_in    = entries_ff;
      entry_sym_in  = entry_sym_ff;
      valid_in      = valid_ff;
      scan_idx_in   = scan_idx_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      io_in         = io_ff;
      root_in       = root_ff;
      walk_in       = walk_ff;
      total_in      = total_ff;
      consumed_in   = consumed_ff;
      byte_in       = byte_ff;
      bit_idx_in    = bit_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_sym_in    = out_sym_ff;
      out_last_in   = out_last_ff;
      freq_we       = 1'b0;
      q_we          = 1'b0;
      q_waddr       = count_ff[7:0];
      q_wdata       = q_rd_ff;
      q_raddr       = 8'd0;
      node_we       = 1'b0;
      prod          = 1'b0;
      prod_sym      = 8'd0;

      if (cmd.clear) begin
         valid_in     = '0;
         entries_in   = 16'd0;
         entry_sym_in = 8'd0;
      end

      if ((cmd.op == OP_MAGIC) || (cmd.op == OP_COUNT) ||
          (cmd.op == OP_FREQ) || (cmd.op == OP_BITS)) begin
         if (done) begin
            seen_in = 3'd0;
            asm_in  = 56'd0;
         end else begin
            seen_in = eff_seen + 3'd1;
            asm_in  = take_asm;
         end
      end

      unique case (cmd.op)
         OP_MAGIC: begin
            if (done && !status.magic_ok) begin
               out_valid_in = 1'b1;
               out_kind_in  = 1'b1;
               out_sym_in   = 8'd0;
               out_last_in  = 1'b1;
            end
         end
         OP_COUNT: begin
            if (done) entries_in = count_val;
         end
         OP_SYM: entry_sym_in = data_byte;
         OP_FREQ: begin
            if (done) begin
               freq_we                = 1'b1;
               valid_in[entry_sym_ff] = 1'b1;
               entries_in             = entries_ff - 16'd1;
            end
         end
         OP_BITS: begin
            if (done) begin
               total_in    = field_full;
               consumed_in = 64'd0;
               scan_idx_in = 8'd0;
               count_in    = 9'd0;
               io_in       = 8'd0;
            end
         end
         OP_PAY: begin
            byte_in    = data_byte;
            bit_idx_in = 3'd7;
         end
         OP_SCAN_WR: begin
            if (fv_rd_ff && (freq_rd_ff != 64'd0)) begin
               q_we     = 1'b1;
               q_wdata  = '{node: {1'b0, scan_idx_ff}, freq: freq_rd_ff};
               count_in = count_ff + 9'd1;
            end
            scan_idx_in = scan_idx_ff + 8'd1;
         end
         OP_Q_LD0: begin
            best_in     = q_rd_ff;
            best_idx_in = 8'd0;
            i_in        = 9'd1;
         end
         OP_Q_RD: q_raddr = i_ff[7:0];
         OP_Q_CMP: begin
            if (is_less) begin
               best_in     = q_rd_ff;
               best_idx_in = i_ff[7:0];
            end
            i_in = i_ff + 9'd1;
         end
         OP_TAIL_RD: begin
            q_raddr  = count_dec[7:0];
            count_in = count_dec;
            if (cmd.second) pb_in = best_ff;
            else pa_in = best_ff;
         end
         OP_TAIL_WR: begin
            q_we    = 1'b1;
            q_waddr = best_idx_ff;
         end
         OP_MERGE: begin
            node_we  = 1'b1;
            q_we     = 1'b1;
            q_wdata  = '{node: {1'b1, io_ff}, freq: pa_ff.freq + pb_ff.freq};
            count_in = count_ff + 9'd1;
            io_in    = io_ff + 8'd1;
         end
         OP_ROOT_LD: begin
            root_in = q_rd_ff.node;
            walk_in = q_rd_ff.node;
         end
         OP_LEAF: begin
            prod        = 1'b1;
            prod_sym    = root_ff[7:0];
            consumed_in = consumed_ff + 64'd1;
            bit_idx_in  = bit_idx_ff - 3'd1;
         end
         OP_EVAL: begin
            if (!child[8]) begin
               prod     = 1'b1;
               prod_sym = child[7:0];
               walk_in  = root_ff;
            end else begin
               walk_in = child;
            end
            consumed_in = consumed_ff + 64'd1;
            bit_idx_in  = bit_idx_ff - 3'd1;
         end
         OP_END: begin
            out_valid_in  = 1'b1;
            out_kind_in   = 1'b0;
            out_sym_in    = pend_sym_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end
         default: begin
         end
      endcase

      // a new symbol pushes the held one out; the held one is last only at byte end
      if (prod) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = 1'b0;
            out_sym_in   = pend_sym_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_sym_in   = prod_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= 3'd0;
         asm_ff        <= 56'd0;
         entries_ff    <= 16'd0;
         entry_sym_ff  <= 8'd0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         count_ff      <= 9'd0;
         io_ff         <= 8'd0;
         root_ff       <= 9'd0;
         walk_ff       <= 9'd0;
         total_ff      <= 64'd0;
         consumed_ff   <= 64'd0;
      end else begin
         seen_ff       <= seen_in;
         asm_ff        <= asm_in;
         entries_ff    <= entries_in;
         entry_sym_ff  <= entry_sym_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         count_ff      <= count_in;
         io_ff         <= io_in;
         root_ff       <= root_in;
         walk_ff       <= walk_in;
         total_ff      <= total_in;
         consumed_ff   <= consumed_in;
      end
      scan_idx_ff <= scan_idx_in;
      i_ff        <= i_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      byte_ff     <= byte_in;
      bit_idx_ff  <= bit_idx_in;
      pend_sym_ff <= pend_sym_in;
      out_kind_ff <= out_kind_in;
      out_sym_ff  <= out_sym_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (freq_we) freq_mem[entry_sym_ff] <= field_full;
      freq_rd_ff <= freq_mem[scan_idx_ff];
      fv_rd_ff   <= valid_ff[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_waddr] <= q_wdata;
      q_rd_ff <= q_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[io_ff] <= {pa_ff.node, pb_ff.node};
      node_rd_ff <= node_mem[walk_ff[7:0]];
   end

   always_comb begin
      status.field_done   = done;
      status.magic_ok     = ({data_byte, eff_asm[23:0]} == MAGIC_WORD);
      status.count_zero   = (count_val == 16'd0);
      status.entries_last = (entries_ff == 16'd1);
      status.bits_zero    = (field_full == 64'd0);
      status.scan_last    = (scan_idx_ff == 8'hFF);
      status.queue_empty  = (count_ff == 9'd0);
      status.queue_one    = (count_ff == 9'd1);
      status.i_end        = (i_ff >= count_ff);
      status.bits_done    = (consumed_ff >= total_ff);
      status.root_leaf    = !root_ff[8];
      status.bit_last     = (bit_idx_ff == 3'd0);
      status.pend_valid   = pend_valid_ff;
      status.out_valid    = out_valid_ff;
      status.out_free     = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_symbol      = out_sym_ff;
   assign rsp_last_result = out_last_ff;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (prod && pend_valid_ff) |-> !out_valid_ff)
      else $error("symbol pushed over a waiting result");

   a_walk_internal: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EVAL) |-> walk_ff[8])
      else $error("walk step from a leaf");

   a_end_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_END) |-> (pend_valid_ff && (!out_valid_ff || rsp_ready)))
      else $error("byte end push without room or held symbol");

endmodule

`default_nettype wire

### rtl/hsd_controller.sv
// state machine sequencing header parse, tree build and payload bit walk
`default_nettype none

module hsd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_file_start,
   input  hsd_pkg::hsd_status_type status,
   output logic                    req_ready,
   output hsd_pkg::hsd_cmd_type    cmd
);
   import hsd_pkg::*;

   localparam logic [4:0] ST_MAGIC   = 5'd0;
   localparam logic [4:0] ST_COUNT   = 5'd1;
   localparam logic [4:0] ST_SYM     = 5'd2;
   localparam logic [4:0] ST_FREQ    = 5'd3;
   localparam logic [4:0] ST_BITS    = 5'd4;
   localparam logic [4:0] ST_PAY     = 5'd5;
   localparam logic [4:0] ST_DEAD    = 5'd6;
   localparam logic [4:0] ST_SCAN_RD = 5'd7;
   localparam logic [4:0] ST_SCAN_WR = 5'd8;
   localparam logic [4:0] ST_CHK0    = 5'd9;
   localparam logic [4:0] ST_LOOP    = 5'd10;
   localparam logic [4:0] ST_Q_RD0   = 5'd11;
   localparam logic [4:0] ST_Q_LD0   = 5'd12;
   localparam logic [4:0] ST_Q_RD    = 5'd13;
   localparam logic [4:0] ST_Q_CMP   = 5'd14;
   localparam logic [4:0] ST_TAIL_WR = 5'd15;
   localparam logic [4:0] ST_MERGE   = 5'd16;
   localparam logic [4:0] ST_ROOT_RD = 5'd17;
   localparam logic [4:0] ST_ROOT_LD = 5'd18;
   localparam logic [4:0] ST_W_BIT   = 5'd19;
   localparam logic [4:0] ST_W_EVAL  = 5'd20;
   localparam logic [4:0] ST_W_END   = 5'd21;

   logic [4:0] state_ff, state_in, eff_state;
   logic       second_ff, second_in;
   logic       accept_state, acc;

   assign accept_state = (state_ff <= ST_DEAD);
   assign req_ready    = accept_state && status.out_free;
   assign acc          = req_valid && req_ready;
   // a file start restarts the parse in any state that accepts input (header, payload or dead)
   assign eff_state    = req_file_start ? ST_MAGIC : state_ff;

   always_comb begin
      state_in   = state_ff;
      second_in  = second_ff;
      cmd.op     = OP_NONE;
      cmd.clear  = acc && req_file_start;
      cmd.second = second_ff;

      unique case (state_ff)
         ST_MAGIC, ST_COUNT, ST_SYM, ST_FREQ, ST_BITS, ST_PAY, ST_DEAD: begin
            if (acc) begin
               unique case (eff_state)
                  ST_MAGIC: begin
                     cmd.op   = OP_MAGIC;
                     state_in = ST_MAGIC;
                     if (status.field_done) state_in = status.magic_ok ? ST_COUNT : ST_DEAD;
                  end
                  ST_COUNT: begin
                     cmd.op = OP_COUNT;
                     if (status.field_done) state_in = status.count_zero ? ST_BITS : ST_SYM;
                  end
                  ST_SYM: begin
                     cmd.op   = OP_SYM;
                     state_in = ST_FREQ;
                  end
                  ST_FREQ: begin
                     cmd.op = OP_FREQ;
                     if (status.field_done) state_in = status.entries_last ? ST_BITS : ST_SYM;
                  end
                  ST_BITS: begin
                     cmd.op = OP_BITS;
                     if (status.field_done) state_in = status.bits_zero ? ST_DEAD : ST_SCAN_RD;
                  end
                  ST_PAY: begin
                     cmd.op   = OP_PAY;
                     state_in = ST_W_BIT;
                  end
                  default: cmd.op = OP_NONE;
               endcase
            end
         end
         ST_SCAN_RD: begin
            cmd.op   = OP_SCAN_RD;
            state_in = ST_SCAN_WR;
         end
         ST_SCAN_WR: begin
            cmd.op   = OP_SCAN_WR;
            state_in = status.scan_last ? ST_CHK0 : ST_SCAN_RD;
         end
         ST_CHK0: state_in = status.queue_empty ? ST_DEAD : ST_LOOP;
         ST_LOOP: state_in = status.queue_one ? ST_ROOT_RD : ST_Q_RD0;
         ST_Q_RD0: begin
            cmd.op   = OP_Q_RD0;
            state_in = ST_Q_LD0;
         end
         ST_Q_LD0: begin
            cmd.op   = OP_Q_LD0;
            state_in = ST_Q_RD;
         end
         ST_Q_RD: begin
            if (status.i_end) begin
               cmd.op   = OP_TAIL_RD;
               state_in = ST_TAIL_WR;
            end else begin
               cmd.op   = OP_Q_RD;
               state_in = ST_Q_CMP;
            end
         end
         ST_Q_CMP: begin
            cmd.op   = OP_Q_CMP;
            state_in = ST_Q_RD;
         end
         ST_TAIL_WR: begin
            cmd.op = OP_TAIL_WR;
            if (second_ff) begin
               state_in = ST_MERGE;
            end else begin
               second_in = 1'b1;
               state_in  = ST_Q_RD0;
            end
         end
         ST_MERGE: begin
            cmd.op    = OP_MERGE;
            second_in = 1'b0;
            state_in  = ST_LOOP;
         end
         ST_ROOT_RD: begin
            cmd.op   = OP_ROOT_RD;
            state_in = ST_ROOT_LD;
         end
         ST_ROOT_LD: begin
            cmd.op   = OP_ROOT_LD;
            state_in = ST_PAY;
         end
         ST_W_BIT: begin
            if (status.bits_done) begin
               state_in = ST_W_END;
            end else if (!status.pend_valid || !status.out_valid) begin
               if (status.root_leaf) begin
                  cmd.op   = OP_LEAF;
                  state_in = status.bit_last ? ST_W_END : ST_W_BIT;
               end else begin
                  cmd.op   = OP_NODE_RD;
                  state_in = ST_W_EVAL;
               end
            end
         end
         ST_W_EVAL: begin
            cmd.op   = OP_EVAL;
            state_in = status.bit_last ? ST_W_END : ST_W_BIT;
         end
         ST_W_END: begin
            if (!status.pend_valid) begin
               state_in = status.bits_done ? ST_DEAD : ST_PAY;
            end else if (status.out_free) begin
               cmd.op   = OP_END;
               state_in = status.bits_done ? ST_DEAD : ST_PAY;
            end
         end
         default: state_in = ST_MAGIC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_MAGIC;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

   a_ready_only_parse: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff <= ST_DEAD))
      else $error("input taken outside a parse state");

   a_second_in_build: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> ((state_ff >= ST_Q_RD0) && (state_ff <= ST_MERGE)))
      else $error("second pop flag outside merge loop");

   a_walk_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_W_EVAL) |-> ($past(cmd.op) == OP_NODE_RD))
      else $error("walk step without node read");

endmodule

`default_nettype wire
